// ===== rtl/core/motion_frame_parser_mapper_core_macros.svh =====
// assertion helpers shared by the core modules
`ifndef MOTION_FRAME_PARSER_MAPPER_CORE_MACROS_SVH
`define MOTION_FRAME_PARSER_MAPPER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define MFPM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MFPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MFPM_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MFPM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/mfpm_pkg.sv =====
`timescale 1ns / 1ps
package mfpm_pkg;

  localparam int FRAME_DEPTH = 14;

  localparam logic [7:0] SYNC_FIRST  = 8'h42;
  localparam logic [7:0] SYNC_DEMAND = 8'h43;
  localparam logic [7:0] SYNC_GOTO   = 8'h47;
  localparam logic [7:0] FRAME_END   = 8'h0D;

  localparam logic [3:0] DEMAND_BYTES = 4'd12;
  localparam logic [3:0] GOTO_BYTES   = 4'd14;

  localparam logic [1:0] MODE_SPLIT = 2'd1;
  localparam logic [1:0] MODE_INTER = 2'd2;

  typedef logic [FRAME_DEPTH-1:0][7:0] frame_t;
  // per pair: first target in [31:16], second in [15:0]
  typedef logic [2:0][31:0] targets_t;

  typedef struct packed {
    targets_t    targets;
    logic [15:0] duration;
    logic        is_goto;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // fixed actuator to pair mapping for both frame layouts
  function automatic targets_t map_targets(frame_t f, logic split);
    logic [5:0][15:0] v;
    targets_t t;
    for (int i = 0; i < 6; i++) begin
      v[i] = split ? {f[i], f[i+6]} : {f[2*i], f[2*i+1]};
    end
    if (split) begin
      t[0] = {v[3], v[4]};
      t[1] = {v[5], v[0]};
      t[2] = {v[1], v[2]};
    end else begin
      t[0] = {v[5], v[0]};
      t[1] = {v[1], v[2]};
      t[2] = {v[3], v[4]};
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/mfpm_front.sv =====
`timescale 1ns / 1ps
module mfpm_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_wr_data,
  input  logic               byte_valid,
  input  logic [7:0]         rx_byte,
  input  logic               system_active,
  output logic               cmd_push,
  output mfpm_pkg::cmd_t     cmd_data
);

  localparam logic [2:0] PH_WAIT_B    = 3'd0;
  localparam logic [2:0] PH_WAIT_KIND = 3'd1;
  localparam logic [2:0] PH_RESERVED  = 3'd2;
  localparam logic [2:0] PH_DATA      = 3'd3;
  localparam logic [2:0] PH_END       = 3'd4;
  localparam logic [2:0] PH_GOTO_DATA = 3'd5;
  localparam logic [2:0] PH_GOTO_END  = 3'd6;

  logic [1:0]       mode_r;
  logic [2:0]       phase_r, phase_nxt;
  logic [3:0]       count_r, count_nxt;
  logic [3:0]       count_inc;
  mfpm_pkg::frame_t frame_r;
  logic             wr_en;
  logic             goto_close;

  assign count_inc = (count_r < 4'd15) ? count_r + 4'd1 : count_r;

  always_comb begin
    phase_nxt  = phase_r;
    count_nxt  = count_r;
    wr_en      = 1'b0;
    cmd_push   = 1'b0;
    goto_close = 1'b0;
    if (byte_valid && mode_r == mfpm_pkg::MODE_SPLIT) begin
      case (phase_r)
        PH_WAIT_B: begin
          phase_nxt = (rx_byte == mfpm_pkg::SYNC_FIRST) ? PH_WAIT_KIND : PH_WAIT_B;
        end
        PH_WAIT_KIND: begin
          if (rx_byte == mfpm_pkg::SYNC_DEMAND) begin
            phase_nxt = PH_RESERVED;
          end else if (rx_byte == mfpm_pkg::SYNC_GOTO) begin
            phase_nxt = PH_GOTO_DATA;
            count_nxt = 4'd0;
          end else begin
            phase_nxt = PH_WAIT_B;
          end
        end
        PH_RESERVED: begin
          phase_nxt = PH_DATA;
          count_nxt = 4'd0;
        end
        PH_DATA: begin
          wr_en     = (count_r < mfpm_pkg::GOTO_BYTES);
          count_nxt = count_inc;
          if (count_inc >= mfpm_pkg::DEMAND_BYTES) phase_nxt = PH_END;
        end
        PH_END: begin
          if (rx_byte == mfpm_pkg::FRAME_END) begin
            cmd_push  = (count_r == mfpm_pkg::DEMAND_BYTES) && system_active;
            phase_nxt = PH_WAIT_B;
          end
        end
        PH_GOTO_DATA: begin
          wr_en     = (count_r < mfpm_pkg::GOTO_BYTES);
          count_nxt = count_inc;
          if (count_inc >= mfpm_pkg::GOTO_BYTES) phase_nxt = PH_GOTO_END;
        end
        PH_GOTO_END: begin
          if (rx_byte == mfpm_pkg::FRAME_END) begin
            cmd_push   = (count_r == mfpm_pkg::GOTO_BYTES) && system_active;
            goto_close = 1'b1;
            phase_nxt  = PH_WAIT_B;
          end
        end
        default: phase_nxt = PH_WAIT_B;
      endcase
    end else if (byte_valid && mode_r == mfpm_pkg::MODE_INTER) begin
      case (phase_r)
        PH_WAIT_B: begin
          phase_nxt = (rx_byte == mfpm_pkg::SYNC_FIRST) ? PH_WAIT_KIND : PH_WAIT_B;
        end
        PH_WAIT_KIND: begin
          phase_nxt = (rx_byte == mfpm_pkg::SYNC_DEMAND) ? PH_DATA : PH_WAIT_B;
          count_nxt = 4'd0;
        end
        PH_DATA: begin
          wr_en     = (count_r < mfpm_pkg::GOTO_BYTES);
          count_nxt = count_inc;
          if (count_inc >= mfpm_pkg::DEMAND_BYTES) phase_nxt = PH_END;
        end
        PH_END: begin
          if (rx_byte == mfpm_pkg::FRAME_END) begin
            cmd_push  = (count_r == mfpm_pkg::DEMAND_BYTES) && system_active;
            phase_nxt = PH_WAIT_B;
          end
        end
        default: phase_nxt = PH_WAIT_B;
      endcase
    end
  end

  always_comb begin
    cmd_data.targets  = mfpm_pkg::map_targets(frame_r, mode_r == mfpm_pkg::MODE_SPLIT);
    cmd_data.is_goto  = goto_close;
    cmd_data.duration = goto_close ? {frame_r[12], frame_r[13]} : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 2'd0;
      phase_r <= PH_WAIT_B;
      count_r <= 4'd0;
    end else if (cfg_wr_en) begin
      mode_r  <= cfg_wr_data;
      phase_r <= PH_WAIT_B;
      count_r <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !cfg_wr_en) begin
      frame_r[count_r] <= rx_byte;
    end
  end

endmodule

// ===== rtl/core/mfpm_queue.sv =====
`timescale 1ns / 1ps
`include "motion_frame_parser_mapper_core_macros.svh"
module mfpm_queue #(
  parameter int DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mfpm_pkg::cmd_t      wr_data,
  input  logic                pop,
  output mfpm_pkg::cmd_t      rd_data,
  output mfpm_pkg::q_status_t status
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  mfpm_pkg::cmd_t  slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;

  assign rd_data      = slot_r[rd_ptr_r];
  assign status.full  = (count_r == DEPTH_CNT);
  assign status.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CW'(1);
        2'b01:   count_r <= count_r - CW'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  `MFPM_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, push, !status.full)
  `MFPM_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, pop, !status.empty)
  `MFPM_ASSERT_NEXT(a_q_push_not_empty, clk, rst_n, push && !pop, !status.empty)

endmodule

// ===== rtl/core/mfpm_back.sv =====
`timescale 1ns / 1ps
`include "motion_frame_parser_mapper_core_macros.svh"
module mfpm_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mfpm_pkg::q_status_t q_status,
  input  mfpm_pkg::cmd_t      cmd_data,
  output logic                cmd_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [55:0]         out_tdata,
  output logic                out_tuser,
  output logic                out_tlast
);

  mfpm_pkg::cmd_t     work_r;
  logic [2:0]         mask_r, mask_nxt;
  logic               busy_r;
  mfpm_pkg::targets_t last_r;
  logic [2:0]         load_mask;
  logic [1:0]         sel;
  logic [2:0]         sel_bit;
  logic               out_free, emit;
  logic               out_valid_r;
  logic [1:0]         pair_r;
  logic [31:0]        tgt_r;
  logic [15:0]        dur_r;
  logic               goto_r, tlast_r;

  assign out_free = !out_valid_r || out_tready;
  assign emit     = busy_r && out_free;
  assign cmd_pop  = !busy_r && !q_status.empty;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      load_mask[i] = cmd_data.is_goto || (cmd_data.targets[i] != last_r[i]);
    end
  end

  always_comb begin
    if (mask_r[0]) begin
      sel = 2'd0; sel_bit = 3'b001;
    end else if (mask_r[1]) begin
      sel = 2'd1; sel_bit = 3'b010;
    end else begin
      sel = 2'd2; sel_bit = 3'b100;
    end
    mask_nxt = mask_r & ~sel_bit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      mask_r      <= 3'b000;
      out_valid_r <= 1'b0;
      last_r      <= '0;
    end else begin
      if (cmd_pop) begin
        busy_r <= (load_mask != 3'b000);
        mask_r <= load_mask;
      end else if (emit) begin
        busy_r      <= (mask_nxt != 3'b000);
        mask_r      <= mask_nxt;
        last_r[sel] <= work_r.targets[sel];
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) work_r <= cmd_data;
    if (emit) begin
      pair_r  <= sel + 2'd1;
      tgt_r   <= work_r.targets[sel];
      dur_r   <= work_r.duration;
      goto_r  <= work_r.is_goto;
      tlast_r <= (mask_nxt == 3'b000);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, dur_r, tgt_r[15:0], tgt_r[31:16], pair_r};
  assign out_tuser  = goto_r;
  assign out_tlast  = tlast_r;

  `MFPM_ASSERT_IMPL(a_busy_has_work, clk, rst_n, busy_r, mask_r != 3'b000)
  `MFPM_ASSERT_NEXT(a_last_frees_back, clk, rst_n, emit && mask_nxt == 3'b000, !busy_r)
  `MFPM_ASSERT_IMPL(a_no_pop_while_busy, clk, rst_n, busy_r, !cmd_pop)

endmodule

// ===== rtl/core/motion_frame_parser_mapper_core.sv =====
`timescale 1ns / 1ps
// results: a closing carriage return with system_active set queues its frame; it is loaded into
//   the result stage and its first changed pair (all for a goto) is registered at the output; the
//   rest follow one per cycle while out_tready is high; one byte per cycle is taken while the
//   queue is not full, and a new frame is loaded only after the last result of the current one
// reset: synchronous active-low rst_n; mode off, parser waiting for sync, queue and output empty,
//   stored pair targets zero
module motion_frame_parser_mapper_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // mode register write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  // byte stream in
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [8] system_active, [15:9] zero
  // pair commands out
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] pair_number, [17:2] first_target, [33:18] second_target,
  // [49:34] move_duration_ms, [55:50] zero
  output logic [55:0] out_tdata,
  output logic        out_tuser,  // [0] is_goto
  output logic        out_tlast   // last_of_run
);

  logic                byte_req;
  logic                cmd_push, cmd_pop;
  mfpm_pkg::cmd_t      push_data, head_data;
  mfpm_pkg::q_status_t q_st;

  // front takes a byte whenever the command queue can absorb a finished frame
  assign in_tready = !q_st.full;
  assign byte_req  = in_tvalid && in_tready;

  // front: framing state machine, frame byte store and pair mapping
  mfpm_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .byte_valid    (byte_req),
    .rx_byte       (in_tdata[7:0]),
    .system_active (in_tdata[8]),
    .cmd_push      (cmd_push),
    .cmd_data      (push_data)
  );

  // queue of mapped frames between parser and result sequencer
  mfpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data (push_data),
    .pop     (cmd_pop),
    .rd_data (head_data),
    .status  (q_st)
  );

  // back: change filter on last sent targets, one result per cycle while out_tready is high
  mfpm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_st),
    .cmd_data   (head_data),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
